// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; bodies vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every rising edge outside reset
`define VCU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("vector clock unit assertion failed");

// check a property on every rising edge, reset included
`define VCU_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("vector clock unit assertion failed");

`else

`define VCU_ASSERT(lbl, clk, rst_n, prop)

`define VCU_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/vcu_pkg.sv
// shared constants, types and helpers for the vector clock unit
// no dependencies
package vcu_pkg;

	localparam int NUM_PROCS = 16;
	localparam int IDX_W     = $clog2(NUM_PROCS);
	localparam int ID_W      = 8;
	localparam int CNT_W     = 31;
	localparam int MODE_W    = 3;
	localparam int ORD_W     = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [ID_W:0]    PROC_LIMIT = (ID_W + 1)'(NUM_PROCS);

	typedef enum logic [MODE_W-1:0] {
		MODE_EVENT   = 3'd0,
		MODE_MERGE   = 3'd1,
		MODE_COMPARE = 3'd2,
		MODE_READ    = 3'd3,
		MODE_WRITE   = 3'd4
	} mode_t;

	typedef enum logic [ORD_W-1:0] {
		ORD_CONCURRENT = 2'd0,
		ORD_BEFORE     = 2'd1,
		ORD_AFTER      = 2'd2
	} order_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_BUMP,
		ST_RES
	} state_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic bump;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_result;
		logic need_bump;
	} dp_status_t;

	function automatic logic id_ok(input logic [ID_W-1:0] id);
		return {1'b0, id} < PROC_LIMIT;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// File: rtl/vcu_ctrl.sv
// sequencer for the vector clock unit: handshakes and per-item steps
// depends on vcu_pkg
module vcu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  vcu_pkg::dp_status_t    status,
	output vcu_pkg::ctrl_cmd_t     cmd
);
	import vcu_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_n  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.need_bump) begin
					state_n = ST_BUMP;
				end else if (status.has_result) begin
					state_n = ST_RES;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_BUMP: begin
				cmd.bump = 1'b1;
				state_n  = ST_RES;
			end
			ST_RES: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/vcu_dp.sv
// datapath of the vector clock unit: counter memory, marks, compare flags
// and the result and output registers; depends on vcu_pkg
module vcu_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [vcu_pkg::ID_W-1:0]    cfg_wr_data,
	input  logic [vcu_pkg::MODE_W-1:0]  mode,
	input  logic [vcu_pkg::ID_W-1:0]    proc_index,
	input  logic [vcu_pkg::CNT_W-1:0]   count,
	input  logic                        last,
	input  vcu_pkg::ctrl_cmd_t          cmd,
	output vcu_pkg::dp_status_t         status,
	output logic [vcu_pkg::CNT_W-1:0]   count_value,
	output logic                        is_present,
	output logic [vcu_pkg::ORD_W-1:0]   order,
	output logic                        id_error
);
	import vcu_pkg::*;

	// configuration and latched item
	logic [ID_W-1:0]   own_id_q;
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;

	// counter memory; valid bits make unwritten entries read as zero
	logic [CNT_W-1:0]     mem_q [NUM_PROCS];
	logic [NUM_PROCS-1:0] valid_q;
	logic [NUM_PROCS-1:0] nz_q;
	logic [NUM_PROCS-1:0] present_q;
	logic [NUM_PROCS-1:0] seen_q;
	logic                 less_q;
	logic                 greater_q;
	logic                 run_err_q;

	logic [CNT_W-1:0] rd_p_q;
	logic [CNT_W-1:0] rd_own_q;
	logic [CNT_W-1:0] own_s_q;

	logic [CNT_W-1:0] res_cnt_q, res_cnt_n;
	logic             res_pres_q, res_pres_n;
	logic [ORD_W-1:0] res_ord_q, res_ord_n;
	logic             res_err_q, res_err_n;

	logic [CNT_W-1:0] count_value_q;
	logic             is_present_q;
	logic [ORD_W-1:0] order_q;
	logic             id_error_q;

	logic [IDX_W-1:0]     ia, io;
	logic                 p_ok, own_ok, here_p;
	logic [CNT_W-1:0]     merged, own_inc, bump_val;
	logic [NUM_PROCS-1:0] p_vec, own_vec, seen_n;
	logic                 less_n, greater_n, greater_f, lt, gt;
	logic [ORD_W-1:0]     ord;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [CNT_W-1:0]     wr_data;

	assign ia       = idx_q[IDX_W-1:0];
	assign io       = own_id_q[IDX_W-1:0];
	assign p_ok     = id_ok(idx_q);
	assign own_ok   = id_ok(own_id_q);
	assign here_p   = p_ok && (present_q[ia] || idx_q == own_id_q);
	assign merged   = (cnt_q > rd_p_q) ? cnt_q : rd_p_q;
	assign own_inc  = sat_inc(rd_own_q);
	assign bump_val = sat_inc(own_s_q);
	assign p_vec    = p_ok ? (NUM_PROCS'(1) << ia) : '0;
	assign own_vec  = own_ok ? (NUM_PROCS'(1) << io) : '0;
	assign seen_n   = seen_q | p_vec;

	// an element absent here always counts as this clock being behind
	assign lt        = p_ok && (!here_p || rd_p_q < cnt_q);
	assign gt        = p_ok && here_p && rd_p_q > cnt_q;
	assign less_n    = less_q | lt;
	assign greater_n = greater_q | gt;
	// entries here but never named by the other clock compare against zero
	assign greater_f = greater_n | (|((present_q | own_vec) & ~seen_n & nz_q));

	always_comb begin
		if (less_n && !greater_f) begin
			ord = ORD_BEFORE;
		end else if (greater_f && !less_n) begin
			ord = ORD_AFTER;
		end else begin
			ord = ORD_CONCURRENT;
		end
	end

	always_comb begin
		status.need_bump  = (mode_q == MODE_MERGE) && last_q && own_ok;
		status.has_result = 1'b0;
		case (mode_q) inside
			MODE_EVENT, MODE_READ:     status.has_result = 1'b1;
			MODE_MERGE, MODE_COMPARE:  status.has_result = last_q;
			MODE_WRITE:                status.has_result = !p_ok;
			default:                   status.has_result = 1'b0;
		endcase
	end

	// write port and next result
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = ia;
		wr_data    = merged;
		res_cnt_n  = '0;
		res_pres_n = 1'b0;
		res_ord_n  = ORD_CONCURRENT;
		res_err_n  = 1'b1;
		if (cmd.exec) begin
			case (mode_q)
				MODE_EVENT: begin
					if (own_ok) begin
						wr_en      = 1'b1;
						wr_addr    = io;
						wr_data    = own_inc;
						res_cnt_n  = own_inc;
						res_pres_n = 1'b1;
						res_err_n  = 1'b0;
					end
				end
				MODE_MERGE: begin
					wr_en = p_ok;
				end
				MODE_COMPARE: begin
					res_ord_n = ord;
					res_err_n = run_err_q | !p_ok;
				end
				MODE_READ: begin
					if (p_ok) begin
						res_cnt_n  = rd_p_q;
						res_pres_n = here_p;
						res_err_n  = 1'b0;
					end
				end
				MODE_WRITE: begin
					wr_en   = p_ok;
					wr_data = cnt_q;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end else if (cmd.bump) begin
			wr_en      = 1'b1;
			wr_addr    = io;
			wr_data    = bump_val;
			res_cnt_n  = bump_val;
			res_pres_n = 1'b1;
			res_err_n  = run_err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.read) begin
			rd_p_q   <= valid_q[ia] ? mem_q[ia] : '0;
			rd_own_q <= valid_q[io] ? mem_q[io] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			idx_q  <= proc_index;
			cnt_q  <= count;
			last_q <= last;
		end
		if (cmd.exec) begin
			// own entry as left by this merge element
			own_s_q <= (p_ok && idx_q == own_id_q) ? merged : rd_own_q;
		end
		if (cmd.exec || cmd.bump) begin
			res_cnt_q  <= res_cnt_n;
			res_pres_q <= res_pres_n;
			res_ord_q  <= res_ord_n;
			res_err_q  <= res_err_n;
		end
		if (cmd.publish) begin
			count_value_q <= res_cnt_q;
			is_present_q  <= res_pres_q;
			order_q       <= res_ord_q;
			id_error_q    <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			valid_q   <= '0;
			nz_q      <= '0;
			present_q <= '0;
			seen_q    <= '0;
			less_q    <= 1'b0;
			greater_q <= 1'b0;
			run_err_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				own_id_q <= cfg_wr_data;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				nz_q[wr_addr]    <= |wr_data;
			end
			if (cmd.exec) begin
				case (mode_q)
					MODE_MERGE: begin
						if (p_ok) begin
							present_q[ia] <= 1'b1;
						end
						if (last_q && !own_ok) begin
							run_err_q <= 1'b0;
						end else begin
							run_err_q <= run_err_q | !p_ok;
						end
					end
					MODE_COMPARE: begin
						if (last_q) begin
							seen_q    <= '0;
							less_q    <= 1'b0;
							greater_q <= 1'b0;
							run_err_q <= 1'b0;
						end else begin
							seen_q    <= seen_n;
							less_q    <= less_n;
							greater_q <= greater_n;
							run_err_q <= run_err_q | !p_ok;
						end
					end
					MODE_WRITE: begin
						if (p_ok) begin
							present_q[ia] <= 1'b1;
						end
					end
					default: begin
						run_err_q <= run_err_q;
					end
				endcase
			end
			if (cmd.bump) begin
				run_err_q <= 1'b0;
			end
		end
	end

	assign count_value = count_value_q;
	assign is_present  = is_present_q;
	assign order       = order_q;
	assign id_error    = id_error_q;

endmodule

// File: rtl/vector_clock_unit.sv
// top level of the vector clock unit: sequencer plus datapath
// depends on vcu_pkg, vcu_ctrl, vcu_dp and assert_macros.svh
`include "assert_macros.svh"

// Vector clock for NUM_PROCS processes (16): one saturating 31-bit counter
// and a present mark per process, own process set through cfg_wr_data. Items
// are taken one at a time. An item is latched, the counter memory is read at
// the element's entry and the own entry, then the update and result are
// formed; the last merge element with a valid own id adds a bump step, a
// second memory write for the own counter, before its result is published.
// Results sit in an output register, so a new item is accepted while the
// previous result waits; a second result waits until that register drains.
// The end-of-compare check over all entries uses per-entry present, seen and
// nonzero bits and is formed combinationally in the compare step.
module vector_clock_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [vcu_pkg::ID_W-1:0]    cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [vcu_pkg::MODE_W-1:0]  mode,
	input  logic [vcu_pkg::ID_W-1:0]    proc_index,
	input  logic [vcu_pkg::CNT_W-1:0]   count,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vcu_pkg::CNT_W-1:0]   count_value,
	output logic                        is_present,
	output logic [vcu_pkg::ORD_W-1:0]   order,
	output logic                        id_error
);
	import vcu_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	vcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vcu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mode        (mode),
		.proc_index  (proc_index),
		.count       (count),
		.last        (last),
		.cmd         (cmd),
		.status      (status),
		.count_value (count_value),
		.is_present  (is_present),
		.order       (order),
		.id_error    (id_error)
	);

	// one item in flight: no transfer in the cycle after one
	`VCU_ASSERT(a_one_item, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	// a result never overwrites one that has not been taken
	`VCU_ASSERT(a_no_overwrite, clk, arst_n, cmd.publish |-> (!out_valid || out_ready))
	// the own-counter bump follows the merge step directly
	`VCU_ASSERT(a_bump_after_exec, clk, arst_n, cmd.bump |-> $past(cmd.exec))
	// at most one step command at a time
	`VCU_ASSERT_ALWAYS(a_cmd_onehot, clk, $onehot0(cmd))

endmodule

// File: tb/vclock_sb_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the vector clock unit testbench: predicts each result and checks it
// depends on vcu_pkg for sizes, mode codes and order codes
package vclock_sb_pkg;
	import vcu_pkg::*;

	typedef struct {
		logic [CNT_W-1:0] count_value;
		logic             is_present;
		order_t           order;
		logic             id_error;
	} clock_result_t;

	class vclock_scoreboard;
		logic [CNT_W-1:0] counters [NUM_PROCS];
		bit               present_m [NUM_PROCS];
		bit               seen_m [NUM_PROCS];
		bit               less_f;
		bit               greater_f;
		bit               run_err;
		logic [ID_W-1:0]  own_id;
		clock_result_t    pending_q [$];
		int               error_count;

		function new();
			error_count = 0;
			clear_state();
		endfunction

		function void clear_state();
			for (int i = 0; i < NUM_PROCS; i++) begin
				counters[i] = '0;
				present_m[i] = 1'b0;
				seen_m[i] = 1'b0;
			end
			less_f = 1'b0;
			greater_f = 1'b0;
			run_err = 1'b0;
			own_id = '0;
			pending_q.delete();
		endfunction

		function void set_own_id(logic [ID_W-1:0] v);
			own_id = v;
		endfunction

		// own entry counts as present even if never written
		function bit here(int p);
			return p < NUM_PROCS && (present_m[p] || p == own_id);
		endfunction

		function bit bump_own();
			if (own_id >= NUM_PROCS)
				return 1'b0;
			if (counters[own_id] != COUNT_MAX)
				counters[own_id] = counters[own_id] + 1'b1;
			return 1'b1;
		endfunction

		function void push_result(logic [CNT_W-1:0] c, logic pr, order_t o, logic e);
			clock_result_t r;
			r.count_value = c;
			r.is_present = pr;
			r.order = o;
			r.id_error = e;
			pending_q.push_back(r);
		endfunction

		function void note_input(logic [MODE_W-1:0] md, logic [ID_W-1:0] p,
			logic [CNT_W-1:0] c, logic lst);
			bit     in_range;
			order_t o;
			in_range = p < NUM_PROCS;
			case (md)
			MODE_EVENT: begin
				if (bump_own())
					push_result(counters[own_id], 1'b1, ORD_CONCURRENT, 1'b0);
				else
					push_result('0, 1'b0, ORD_CONCURRENT, 1'b1);
			end
			MODE_MERGE: begin
				if (in_range) begin
					if (c > counters[p])
						counters[p] = c;
					present_m[p] = 1'b1;
				end else begin
					run_err = 1'b1;
				end
				if (lst) begin
					if (bump_own())
						push_result(counters[own_id], 1'b1, ORD_CONCURRENT, run_err);
					else
						push_result('0, 1'b0, ORD_CONCURRENT, 1'b1);
					run_err = 1'b0;
				end
			end
			MODE_COMPARE: begin
				if (in_range) begin
					seen_m[p] = 1'b1;
					if (here(p)) begin
						if (counters[p] < c)
							less_f = 1'b1;
						if (counters[p] > c)
							greater_f = 1'b1;
					end else begin
						less_f = 1'b1;
					end
				end else begin
					run_err = 1'b1;
				end
				if (lst) begin
					// entries the other clock never sent count as zero there
					for (int i = 0; i < NUM_PROCS; i++)
						if (here(i) && !seen_m[i] && counters[i] != '0)
							greater_f = 1'b1;
					if (less_f && !greater_f)
						o = ORD_BEFORE;
					else if (greater_f && !less_f)
						o = ORD_AFTER;
					else
						o = ORD_CONCURRENT;
					push_result('0, 1'b0, o, run_err);
					for (int i = 0; i < NUM_PROCS; i++)
						seen_m[i] = 1'b0;
					less_f = 1'b0;
					greater_f = 1'b0;
					run_err = 1'b0;
				end
			end
			MODE_READ: begin
				if (in_range)
					push_result(counters[p], here(p), ORD_CONCURRENT, 1'b0);
				else
					push_result('0, 1'b0, ORD_CONCURRENT, 1'b1);
			end
			MODE_WRITE: begin
				if (in_range) begin
					counters[p] = c;
					present_m[p] = 1'b1;
				end else begin
					push_result('0, 1'b0, ORD_CONCURRENT, 1'b1);
				end
			end
			default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t: result mismatch: %s", $time, msg);
			error_count++;
		endtask

		task check_result(logic [CNT_W-1:0] c, logic pr, logic [ORD_W-1:0] o, logic e);
			clock_result_t want;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected transfer count_value=%0d is_present=%0b order=%0d id_error=%0b",
					c, pr, o, e));
				return;
			end
			want = pending_q.pop_front();
			if (c !== want.count_value)
				report_mismatch($sformatf("count_value %0d, wanted %0d", c, want.count_value));
			if (pr !== want.is_present)
				report_mismatch($sformatf("is_present %0b, wanted %0b", pr, want.is_present));
			if (o !== want.order)
				report_mismatch($sformatf("order %0d, wanted %0d", o, want.order));
			if (e !== want.id_error)
				report_mismatch($sformatf("id_error %0b, wanted %0b", e, want.id_error));
		endtask
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// top of the vector clock unit testbench: clock, reset, item driver, result receiver, watchdog
// depends on vcu_pkg, vclock_sb_pkg and the vector_clock_unit rtl
module tb_top;
	import vcu_pkg::*;
	import vclock_sb_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 125;
	localparam int ID_TOP      = 2**ID_W - 1;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [ID_W-1:0]   cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [ID_W-1:0]   proc_index = '0;
	logic [CNT_W-1:0]  count = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CNT_W-1:0]  count_value;
	logic              is_present;
	logic [ORD_W-1:0]  order;
	logic              id_error;

	vclock_scoreboard sb;
	int items_sent = 0;
	int send_calm = 0;
	int recv_calm = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;

	vector_clock_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.proc_index  (proc_index),
		.count       (count),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_value (count_value),
		.is_present  (is_present),
		.order       (order),
		.id_error    (id_error)
	);

	always #6 clk = ~clk;

	// mostly random gaps, with runs of back-to-back transfers now and then
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [CNT_W-1:0] random_count();
		case ($urandom_range(0, 9))
		0: return COUNT_MAX - CNT_W'($urandom_range(0, 2));
		1, 2, 3, 4: return CNT_W'($urandom_range(0, 20));
		default: return CNT_W'($urandom());
		endcase
	endfunction

	function automatic logic [ID_W-1:0] random_proc(int bad_odds);
		if ($urandom_range(1, bad_odds) == 1)
			return ID_W'($urandom_range(NUM_PROCS, ID_TOP));
		return ID_W'($urandom_range(0, NUM_PROCS - 1));
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] p,
		input logic [CNT_W-1:0] c, input logic l);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		proc_index <= p;
		count <= c;
		last <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_input(m, p, c, l);
		items_sent++;
		@(negedge clk);
	endtask

	// in-range writes and non-last elements give no result, so allow for one still in flight
	task automatic wait_idle();
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_own_id(input logic [ID_W-1:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_own_id(v);
	endtask

	task automatic send_merge_run();
		int n;
		n = $urandom_range(1, 4);
		for (int j = 0; j < n; j++)
			send_item(MODE_MERGE, random_proc(10), random_count(), j == n - 1);
	endtask

	// builds the other clock from our own copy, nudged toward a chosen outcome
	task automatic send_compare_run();
		int picks [$];
		int tgt;
		int k;
		int tmp;
		logic [CNT_W-1:0] v;
		tgt = $urandom_range(0, 3);
		for (int i = 0; i < NUM_PROCS; i++) begin
			if (sb.here(i)) begin
				if ($urandom_range(0, 9) != 0)
					picks.push_back(i);
			end else if ($urandom_range(0, 5) == 0) begin
				picks.push_back(i);
			end
		end
		if (picks.size() == 0)
			picks.push_back(int'($urandom_range(0, NUM_PROCS - 1)));
		for (int j = picks.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = picks[j];
			picks[j] = picks[k];
			picks[k] = tmp;
		end
		if ($urandom_range(0, 9) == 0)
			send_item(MODE_COMPARE, random_proc(1), random_count(), 1'b0);
		for (int j = 0; j < picks.size(); j++) begin
			v = sb.counters[picks[j]];
			if (j == 0 && tgt == 1)
				v = v + 1'b1;
			else if (j == 0 && tgt == 2 && v != '0)
				v = v - 1'b1;
			else if (tgt == 3 && $urandom_range(0, 1) == 1)
				v = random_count();
			send_item(MODE_COMPARE, ID_W'(picks[j]), v, j == picks.size() - 1);
		end
	endtask

	task automatic send_noise();
		send_item(MODE_W'($urandom_range(MODE_EVENT, MODE_WRITE)), random_proc(6),
			random_count(), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_phase(input logic [ID_W-1:0] id, input bit with_hold);
		int target;
		write_own_id(id);
		if (with_hold)
			hold_req = 1'b1;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
			0, 1, 2: send_merge_run();
			3, 4, 5, 6: send_compare_run();
			default: send_noise();
			endcase
		end
		in_valid <= 1'b0;
	endtask

	task automatic directed_items();
		send_item(MODE_READ, 0, 0, 1'b0);
		send_item(MODE_READ, ID_W'(NUM_PROCS - 1), COUNT_MAX, 1'b1);
		send_item(MODE_READ, ID_W'(ID_TOP), 0, 1'b0);
		send_item(MODE_EVENT, 0, 0, 1'b0);
		send_item(MODE_WRITE, 3, COUNT_MAX, 1'b0);
		send_item(MODE_READ, 3, 0, 1'b0);
		send_item(MODE_WRITE, ID_W'(NUM_PROCS), 5, 1'b0);
		// own counter up to saturation
		send_item(MODE_WRITE, 0, COUNT_MAX - 1'b1, 1'b0);
		send_item(MODE_EVENT, 0, 0, 1'b0);
		send_item(MODE_EVENT, 0, 0, 1'b1);
		// merge with a bad id in the middle
		send_item(MODE_MERGE, 5, 7, 1'b0);
		send_item(MODE_MERGE, ID_W'(ID_TOP), 0, 1'b0);
		send_item(MODE_MERGE, 3, 0, 1'b1);
		// equal clocks
		send_item(MODE_COMPARE, 0, COUNT_MAX, 1'b0);
		send_item(MODE_COMPARE, 3, COUNT_MAX, 1'b0);
		send_item(MODE_COMPARE, 5, 7, 1'b1);
		// other ahead on the entries it sends, one of them absent here
		send_item(MODE_COMPARE, 5, 8, 1'b0);
		send_item(MODE_COMPARE, 9, 1, 1'b1);
		// other missing nonzero entries
		send_item(MODE_COMPARE, 0, COUNT_MAX, 1'b1);
		send_item(MODE_COMPARE, 5, 8, 1'b1);
		send_item(MODE_COMPARE, ID_W'(NUM_PROCS), 3, 1'b1);
		send_item(MODE_SPARE_LO, 2, 9, 1'b1);
		send_item(MODE_SPARE_HI, 0, COUNT_MAX, 1'b0);
		send_item(MODE_MERGE, 1, 2, 1'b1);
		send_item(MODE_WRITE, 0, 0, 1'b0);
		send_item(MODE_READ, 0, 0, 1'b0);
		in_valid <= 1'b0;
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(count_value, is_present, order, id_error);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				// long hold so the output register fills and the input stalls
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = draw_gap(recv_calm);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		run_phase(ID_W'(NUM_PROCS - 1), 1'b1);
		run_phase(ID_W'(ID_TOP), 1'b0);
		run_phase(ID_W'($urandom_range(1, NUM_PROCS - 2)), 1'b0);
		run_phase(ID_W'(NUM_PROCS), 1'b0);
		run_phase(ID_W'(0), 1'b0);
		run_phase(ID_W'($urandom_range(0, ID_TOP)), 1'b0);
		wait_idle();
		repeat (12) @(posedge clk);
		if (sb.pending_q.size() != 0)
			sb.report_mismatch($sformatf("%0d expected results never arrived",
				sb.pending_q.size()));
		if (sb.error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/vcu_pkg.sv
rtl/vcu_ctrl.sv
rtl/vcu_dp.sv
rtl/vector_clock_unit.sv
tb/vclock_sb_pkg.sv
tb/tb_top.sv
